// ----- sv/mhe_pkg.sv -----
// Shared types and constants for the masked histogram equalizer.
package mhe_pkg;

   // Width of a bin count, of the pixel total and of the cumulative sum.
   localparam int CNT_W = 31;
   localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFF_FFFF;

   // Fraction bits of the gain register.
   localparam int GAIN_FRAC = 14;

   // Configuration register indexes.
   localparam logic [2:0] REG_FAST_DIM    = 3'd0;
   localparam logic [2:0] REG_MID_DIM     = 3'd1;
   localparam logic [2:0] REG_SLICE_COUNT = 3'd2;
   localparam logic [2:0] REG_MARGIN      = 3'd3;
   localparam logic [2:0] REG_MAX_LEVEL   = 3'd4;
   localparam logic [2:0] REG_GAIN        = 3'd5;

   // Table build sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FREAD,
      ST_FDATA,
      ST_NEXT,
      ST_ACC,
      ST_MUL,
      ST_DIVI,
      ST_DIV,
      ST_WR,
      ST_DONE
   } state_type;

endpackage

// ----- sv/masked_histogram_equalizer.sv -----
// Top level of the masked histogram equalizer: counting pass, table build, mapping pass.
//
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_op, req_pixel, req_last
// rsp       out        rsp_valid/rsp_ready  rsp_level, rsp_last_out
// csr       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// Both passes take one pixel per cycle, the mapping pass only while the result register
// is free; the bin memory read-modify-write pipeline forwards the last written count, so
// equal pixels may follow back to back. After the last pixel of the counting pass, the
// table build holds req_ready low until done; an entry outside the equalized range is
// written at once, one inside it is summed, multiplied and, unless saturated, divided.
// Reset clears the bin valid bits at once; there is no clearing pass.
// A stalled result register stalls the mapping pipeline one stage deep.
module masked_histogram_equalizer #(
   parameter int MAX_DIM = 1024,
   parameter int BINS    = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_pixel,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_level,
   output logic        rsp_last_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int PW = $clog2(MAX_DIM);
   localparam int SW = ((PW > 11) ? PW : 11) + 2;
   localparam int CW = mhe_pkg::CNT_W;
   localparam int NW = 57;
   localparam logic [BW-1:0] LAST_BIN = BW'(BINS - 1);

   // Configuration registers.
   logic [10:0] fast_dim_ff, mid_dim_ff, slice_count_ff;
   logic [9:0]  margin_ff;
   logic [7:0]  max_level_ff;
   logic [15:0] gain_ff;
   logic        csr_wr;
   logic [2:0]  reg_idx;

   // Stream and pipeline state.
   mhe_pkg::state_type state_ff, state_in;
   logic [PW-1:0] pos_fast_ff, pos_fast_in, pos_mid_ff, pos_mid_in, pos_slice_ff, pos_slice_in;
   logic          s1_v_ff, s1_v_in;
   logic          s1_op_ff, s1_last_ff, s1_oob_ff;
   logic [BW-1:0] s1_bin_ff;
   logic          fwd_v_ff, fwd_v_in;
   logic [BW-1:0] fwd_addr_ff;
   logic [CW-1:0] fwd_val_ff;
   logic [BINS-1:0] vld_ff, vld_in;
   logic [CW-1:0] total_ff, total_in;
   logic [BW-1:0] min_ff, min_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_level_ff;
   logic          rsp_last_ff;
   logic          uniform_ff, uniform_in;
   logic [7:0]    ulevel_ff, ulevel_in;

   // Build datapath.
   logic [BW-1:0] b_ff, b_in;
   logic [CW-1:0] d_ff, d_in, sum_ff, sum_in;
   logic [23:0]   mlg_ff, mlg_in;
   logic [54:0]   prod_ff, prod_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [8:0]    q_ff, q_in;
   logic [3:0]    i_ff, i_in;

   // Memories.
   logic [CW-1:0] bin_mem [BINS];
   logic [7:0]    tab_mem [BINS];
   logic [CW-1:0] bin_rdata_ff;
   logic [7:0]    tab_rdata_ff;
   logic          bin_ren, bin_we, tab_ren, tab_we;
   logic [BW-1:0] bin_raddr;
   logic [CW-1:0] bin_wdata;
   logic [7:0]    tab_wdata;

   // Combinational helpers.
   logic          accept, out_free, s1_adv, s1_wr;
   logic signed [SW-1:0] fd, md, sc, mg, kk, jj, ii, mid, kn, jn, inx;
   logic          in_win, pix_oob;
   logic [BW-1:0] bin_sel;
   logic [CW-1:0] cur_cnt, new_cnt, mem_cnt;
   logic [CW:0]   sum_wide;
   logic [NW-1:0] num, den9, den_sh;
   logic          in_range;

   function automatic logic signed [SW-1:0] ext_f(input logic [10:0] v);
      logic signed [SW-1:0] vx;
      vx = {{(SW-11){1'b0}}, v};
      if (v == 11'd0) begin
         return SW'(1);
      end else if (vx > SW'(MAX_DIM)) begin
         return SW'(MAX_DIM);
      end
      return vx;
   endfunction

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v == mhe_pkg::CNT_MAX) ? v : v + CW'(1);
   endfunction

   // Configuration port.
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      case (reg_idx)
         mhe_pkg::REG_FAST_DIM:    prdata = 32'(fast_dim_ff);
         mhe_pkg::REG_MID_DIM:     prdata = 32'(mid_dim_ff);
         mhe_pkg::REG_SLICE_COUNT: prdata = 32'(slice_count_ff);
         mhe_pkg::REG_MARGIN:      prdata = 32'(margin_ff);
         mhe_pkg::REG_MAX_LEVEL:   prdata = 32'(max_level_ff);
         mhe_pkg::REG_GAIN:        prdata = 32'(gain_ff);
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_dim_ff    <= 11'd256;
         mid_dim_ff     <= 11'd256;
         slice_count_ff <= 11'd1;
         margin_ff      <= 10'd64;
         max_level_ff   <= 8'd255;
         gain_ff        <= 16'd16384;
      end else if (csr_wr) begin
         case (reg_idx)
            mhe_pkg::REG_FAST_DIM:    fast_dim_ff    <= pwdata[10:0];
            mhe_pkg::REG_MID_DIM:     mid_dim_ff     <= pwdata[10:0];
            mhe_pkg::REG_SLICE_COUNT: slice_count_ff <= pwdata[10:0];
            mhe_pkg::REG_MARGIN:      margin_ff      <= pwdata[9:0];
            mhe_pkg::REG_MAX_LEVEL:   max_level_ff   <= pwdata[7:0];
            mhe_pkg::REG_GAIN:        gain_ff        <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Handshake and stage one flow.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_v_ff && (!s1_op_ff || out_free);
   assign s1_wr     = s1_v_ff && !s1_op_ff;
   assign req_ready = (state_ff == mhe_pkg::ST_IDLE) &&
                      !(s1_v_ff && !s1_op_ff && s1_last_ff) &&
                      !(s1_v_ff && s1_op_ff && !out_free);
   assign accept    = req_valid && req_ready;

   // Window test on the scan position and next position.
   always_comb begin
      fd  = ext_f(fast_dim_ff);
      md  = ext_f(mid_dim_ff);
      sc  = ext_f(slice_count_ff);
      mg  = {{(SW-10){1'b0}}, margin_ff};
      kk  = {{(SW-PW){1'b0}}, pos_fast_ff};
      jj  = {{(SW-PW){1'b0}}, pos_mid_ff};
      ii  = {{(SW-PW){1'b0}}, pos_slice_ff};
      mid = (sc == SW'(1)) ? SW'(1) : (sc >>> 1);
      in_win = (jj > mg) && (jj < md - mg) && (kk > mg) && (kk < fd - mg) &&
               ((ii == mid - SW'(2)) || (ii == mid - SW'(1)) || (ii == mid));
      pix_oob = ({1'b0, req_pixel} >= 9'(BINS));
      if (!in_win) begin
         bin_sel = '0;
      end else if (pix_oob) begin
         bin_sel = LAST_BIN;
      end else begin
         bin_sel = req_pixel[BW-1:0];
      end
      kn  = kk + SW'(1);
      jn  = jj;
      inx = ii;
      if (kn >= fd) begin
         kn = '0;
         jn = jj + SW'(1);
         if (jn >= md) begin
            jn  = '0;
            inx = ii + SW'(1);
            if (inx >= sc) begin
               inx = '0;
            end
         end
      end
   end

   // Count update with forwarding of the previous write.
   always_comb begin
      mem_cnt = vld_ff[s1_bin_ff] ? bin_rdata_ff : '0;
      cur_cnt = (fwd_v_ff && (fwd_addr_ff == s1_bin_ff)) ? fwd_val_ff : mem_cnt;
      new_cnt = sat_inc(cur_cnt);
   end

   // Build arithmetic.
   always_comb begin
      sum_wide = {1'b0, sum_ff} + {1'b0, (vld_ff[b_ff] ? bin_rdata_ff : '0)};
      num      = NW'({prod_ff, 1'b0}) + NW'({d_ff, 14'b0});
      den9     = NW'({d_ff, 24'b0});
      den_sh   = NW'({d_ff, 15'b0}) << i_ff;
      in_range = (b_ff > min_ff) && (9'(b_ff) <= 9'(max_level_ff));
   end

   // Sequencer, next state and register updates.
   always_comb begin
      state_in     = state_ff;
      pos_fast_in  = pos_fast_ff;
      pos_mid_in   = pos_mid_ff;
      pos_slice_in = pos_slice_ff;
      s1_v_in      = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
      fwd_v_in     = fwd_v_ff;
      vld_in       = vld_ff;
      total_in     = total_ff;
      min_in       = min_ff;
      rsp_valid_in = (s1_v_ff && s1_op_ff && out_free) ? 1'b1 :
                     (rsp_ready ? 1'b0 : rsp_valid_ff);
      uniform_in   = uniform_ff;
      ulevel_in    = ulevel_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      sum_in       = sum_ff;
      mlg_in       = mlg_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      i_in         = i_ff;
      bin_ren      = 1'b0;
      bin_raddr    = bin_sel;
      bin_we       = 1'b0;
      bin_wdata    = new_cnt;
      tab_ren      = 1'b0;
      tab_we       = 1'b0;
      tab_wdata    = 8'd0;

      case (state_ff)
         mhe_pkg::ST_IDLE: begin
            if (accept && !req_op) begin
               bin_ren      = 1'b1;
               pos_fast_in  = kn[PW-1:0];
               pos_mid_in   = jn[PW-1:0];
               pos_slice_in = inx[PW-1:0];
            end
            if (accept && req_op) begin
               tab_ren = 1'b1;
            end
            if (s1_wr) begin
               bin_we            = 1'b1;
               fwd_v_in          = 1'b1;
               vld_in[s1_bin_ff] = 1'b1;
               total_in          = sat_inc(total_ff);
               if (s1_bin_ff < min_ff) begin
                  min_in = s1_bin_ff;
               end
               if (s1_last_ff) begin
                  state_in = mhe_pkg::ST_FREAD;
               end
            end
         end
         mhe_pkg::ST_FREAD: begin
            bin_ren   = 1'b1;
            bin_raddr = min_ff;
            mlg_in    = 24'(max_level_ff) * 24'(gain_ff);
            state_in  = mhe_pkg::ST_FDATA;
         end
         mhe_pkg::ST_FDATA: begin
            if ((vld_ff[min_ff] ? bin_rdata_ff : '0) >= total_ff) begin
               uniform_in = 1'b1;
               ulevel_in  = 8'(min_ff);
               state_in   = mhe_pkg::ST_DONE;
            end else begin
               uniform_in = 1'b0;
               d_in       = total_ff - (vld_ff[min_ff] ? bin_rdata_ff : '0);
               b_in       = '0;
               sum_in     = '0;
               state_in   = mhe_pkg::ST_NEXT;
            end
         end
         mhe_pkg::ST_NEXT: begin
            if (in_range) begin
               bin_ren   = 1'b1;
               bin_raddr = b_ff;
               state_in  = mhe_pkg::ST_ACC;
            end else begin
               tab_we = 1'b1;
               if (b_ff == LAST_BIN) begin
                  state_in = mhe_pkg::ST_DONE;
               end else begin
                  b_in = b_ff + BW'(1);
               end
            end
         end
         mhe_pkg::ST_ACC: begin
            sum_in   = sum_wide[CW] ? mhe_pkg::CNT_MAX :
                       ((sum_wide[CW-1:0] > mhe_pkg::CNT_MAX) ? mhe_pkg::CNT_MAX
                                                              : sum_wide[CW-1:0]);
            state_in = mhe_pkg::ST_MUL;
         end
         mhe_pkg::ST_MUL: begin
            prod_in  = 55'(sum_ff) * 55'(mlg_ff);
            state_in = mhe_pkg::ST_DIVI;
         end
         mhe_pkg::ST_DIVI: begin
            // A quotient of 512 or more always clamps, so skip the division.
            if (num >= den9) begin
               q_in     = '1;
               state_in = mhe_pkg::ST_WR;
            end else begin
               rem_in   = num;
               q_in     = '0;
               i_in     = 4'd8;
               state_in = mhe_pkg::ST_DIV;
            end
         end
         mhe_pkg::ST_DIV: begin
            // One quotient bit per cycle, most significant first.
            if (rem_ff >= den_sh) begin
               rem_in       = rem_ff - den_sh;
               q_in[i_ff]   = 1'b1;
            end
            if (i_ff == 4'd0) begin
               state_in = mhe_pkg::ST_WR;
            end else begin
               i_in = i_ff - 4'd1;
            end
         end
         mhe_pkg::ST_WR: begin
            tab_we    = 1'b1;
            tab_wdata = (q_ff > {1'b0, max_level_ff}) ? max_level_ff : q_ff[7:0];
            if (b_ff == LAST_BIN) begin
               state_in = mhe_pkg::ST_DONE;
            end else begin
               b_in     = b_ff + BW'(1);
               state_in = mhe_pkg::ST_NEXT;
            end
         end
         mhe_pkg::ST_DONE: begin
            vld_in       = '0;
            total_in     = '0;
            min_in       = LAST_BIN;
            fwd_v_in     = 1'b0;
            pos_fast_in  = '0;
            pos_mid_in   = '0;
            pos_slice_in = '0;
            state_in     = mhe_pkg::ST_IDLE;
         end
         default: begin
            state_in = mhe_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhe_pkg::ST_IDLE;
         pos_fast_ff  <= '0;
         pos_mid_ff   <= '0;
         pos_slice_ff <= '0;
         s1_v_ff      <= 1'b0;
         fwd_v_ff     <= 1'b0;
         vld_ff       <= '0;
         total_ff     <= '0;
         min_ff       <= LAST_BIN;
         rsp_valid_ff <= 1'b0;
         uniform_ff   <= 1'b0;
         ulevel_ff    <= 8'd0;
         i_ff         <= 4'd0;
         b_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         pos_fast_ff  <= pos_fast_in;
         pos_mid_ff   <= pos_mid_in;
         pos_slice_ff <= pos_slice_in;
         s1_v_ff      <= s1_v_in;
         fwd_v_ff     <= fwd_v_in;
         vld_ff       <= vld_in;
         total_ff     <= total_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         uniform_ff   <= uniform_in;
         ulevel_ff    <= ulevel_in;
         i_ff         <= i_in;
         b_ff         <= b_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_op;
         s1_last_ff <= req_last;
         s1_bin_ff  <= bin_sel;
         s1_oob_ff  <= pix_oob;
      end
      if (bin_we) begin
         fwd_addr_ff <= s1_bin_ff;
         fwd_val_ff  <= new_cnt;
      end
      if (s1_v_ff && s1_op_ff && out_free) begin
         rsp_level_ff <= uniform_ff ? ulevel_ff : (s1_oob_ff ? 8'd0 : tab_rdata_ff);
         rsp_last_ff  <= s1_last_ff;
      end
      d_ff    <= d_in;
      sum_ff  <= sum_in;
      mlg_ff  <= mlg_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
   end

   // Bin count memory.
   always_ff @(posedge clock) begin
      if (bin_ren) begin
         bin_rdata_ff <= bin_mem[bin_raddr];
      end
      if (bin_we) begin
         bin_mem[s1_bin_ff] <= bin_wdata;
      end
   end

   // Mapping table memory.
   always_ff @(posedge clock) begin
      if (tab_ren) begin
         tab_rdata_ff <= tab_mem[req_pixel[BW-1:0]];
      end
      if (tab_we) begin
         tab_mem[b_ff] <= tab_wdata;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_last_out = rsp_last_ff;

   // No transaction is taken while the table is being built.
   a_no_accept_in_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mhe_pkg::ST_IDLE) |-> !req_ready)
      else $error("input accepted during table build");

   // The end of a build leaves an empty histogram.
   a_cleared_after_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mhe_pkg::ST_DONE) |=> ((vld_ff == '0) && (total_ff == '0)))
      else $error("histogram not cleared after build");

   // The divider never runs past its top quotient bit.
   a_div_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mhe_pkg::ST_DIV) |-> (i_ff <= 4'd8))
      else $error("divider index out of range");

   // Every count write is captured for forwarding to the next read.
   a_forward_capture: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mhe_pkg::ST_IDLE && s1_wr) |=>
      (fwd_v_ff && (fwd_addr_ff == $past(s1_bin_ff))))
      else $error("forwarding register missed a count write");

endmodule

// ----- bench/mhe_checker.sv -----
// Scoreboard for the masked histogram equalizer: bin counting, table build and level checks.
module mhe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_pixel,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_level,
   input  logic        rsp_last_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_LIMIT = 1024;
   localparam longint unsigned UNIT_GAIN = 64'd16384;

   typedef struct packed {
      logic [7:0] level;
      logic       last_out;
   } level_result_type;

   // Mirrored configuration.
   logic [10:0] fast_dim, mid_dim, slice_count;
   logic [9:0]  margin;
   logic [7:0]  max_level;
   logic [15:0] gain;

   // Mirrored state of the equalizer.
   logic [mhe_pkg::CNT_W-1:0] hist[256];
   logic [7:0]                lut[256];
   int                        at_fast, at_mid, at_slice;
   logic [mhe_pkg::CNT_W-1:0] total_px;
   logic                      flat;
   logic [7:0]                flat_level;

   level_result_type level_queue[$];

   assign outstanding = level_queue.size();

   function automatic int clip_extent(logic [10:0] v);
      if (v == 0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return int'(v);
   endfunction

   function automatic logic [mhe_pkg::CNT_W-1:0] bump(logic [mhe_pkg::CNT_W-1:0] v);
      return (v == mhe_pkg::CNT_MAX) ? v : v + 1'b1;
   endfunction

   // Cumulative look-up table from the finished histogram, then start a fresh volume.
   task automatic equalize();
      int first;
      longint unsigned spread, denom, acc, quo;
      first = 0;
      for (int b = 0; b < 256; b++) lut[b] = '0;
      while (first < 255 && hist[first] == 0) first++;
      spread = longint'(total_px) - longint'(hist[first]);
      if (hist[first] >= total_px) begin
         flat = 1'b1;
         flat_level = first[7:0];
      end else begin
         flat = 1'b0;
         acc = 0;
         denom = 2 * spread * UNIT_GAIN;
         for (int b = first + 1; b < 256 && b <= int'(max_level); b++) begin
            acc += hist[b];
            if (acc > mhe_pkg::CNT_MAX) acc = mhe_pkg::CNT_MAX;
            quo = (2 * acc * max_level * gain + spread * UNIT_GAIN) / denom;
            if (quo > max_level) quo = max_level;
            lut[b] = quo[7:0];
         end
      end
      for (int b = 0; b < 256; b++) hist[b] = '0;
      total_px = '0;
      at_fast = 0;
      at_mid = 0;
      at_slice = 0;
   endtask

   // Count one pass-0 pixel at the current scan position and advance the position.
   task automatic count_pixel(logic [7:0] pix);
      int fd, md, sc, mg, centre;
      logic in_window;
      logic [7:0] bin;
      fd = clip_extent(fast_dim);
      md = clip_extent(mid_dim);
      sc = clip_extent(slice_count);
      mg = int'(margin);
      centre = (sc == 1) ? 1 : sc / 2;
      in_window = at_mid > mg && at_mid < md - mg && at_fast > mg && at_fast < fd - mg &&
                  (at_slice == centre - 2 || at_slice == centre - 1 || at_slice == centre);
      bin = in_window ? pix : 8'd0;
      hist[bin] = bump(hist[bin]);
      total_px = bump(total_px);
      at_fast++;
      if (at_fast >= fd) begin
         at_fast = 0;
         at_mid++;
         if (at_mid >= md) begin
            at_mid = 0;
            at_slice++;
            if (at_slice >= sc) at_slice = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      level_result_type want;
      level_result_type got;
      int errs;
      errs = 0;
      if (reset) begin
         fast_dim <= 11'd256;
         mid_dim <= 11'd256;
         slice_count <= 11'd1;
         margin <= 10'd64;
         max_level <= 8'd255;
         gain <= 16'd16384;
         for (int b = 0; b < 256; b++) begin
            hist[b] = '0;
            lut[b] = '0;
         end
         at_fast = 0;
         at_mid = 0;
         at_slice = 0;
         total_px = '0;
         flat = 1'b0;
         flat_level = '0;
         level_queue.delete();
         fail_count <= 0;
      end else begin
         // Register writes.
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               mhe_pkg::REG_FAST_DIM:    fast_dim <= pwdata[10:0];
               mhe_pkg::REG_MID_DIM:     mid_dim <= pwdata[10:0];
               mhe_pkg::REG_SLICE_COUNT: slice_count <= pwdata[10:0];
               mhe_pkg::REG_MARGIN:      margin <= pwdata[9:0];
               mhe_pkg::REG_MAX_LEVEL:   max_level <= pwdata[7:0];
               mhe_pkg::REG_GAIN:        gain <= pwdata[15:0];
               default: ;
            endcase
         end

         // Result transactions are compared with the oldest expected level.
         if (rsp_valid && rsp_ready) begin
            got = '{level: rsp_level, last_out: rsp_last_out};
            if (level_queue.size() == 0) begin
               $error("unexpected result transaction: level %0d last_out %0b",
                      got.level, got.last_out);
               errs++;
            end else begin
               want = level_queue.pop_front();
               if (got.level !== want.level) begin
                  $error("level: expected %0d, actual %0d", want.level, got.level);
                  errs++;
               end
               if (got.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
                  errs++;
               end
            end
         end

         // Input transactions update the mirrored state.
         if (req_valid && req_ready) begin
            if (req_op) begin
               want.level = flat ? flat_level : lut[req_pixel];
               want.last_out = req_last;
               level_queue = {level_queue, want};
            end else begin
               count_pixel(req_pixel);
               if (req_last) equalize();
            end
         end

         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

// ----- bench/masked_histogram_equalizer_tb.sv -----
// Stimulus and verdict for the masked histogram equalizer, with the scoreboard beside it.
module masked_histogram_equalizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [7:0]  req_pixel = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_level;
   logic        rsp_last_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          outstanding;

   // Run-wide controls and tallies.
   bit quiet = 1'b0;
   bit long_hold = 1'b0;
   int sent = 0;
   int volumes = 0;
   int leftover = 0;

   always #2 clock = ~clock;

   masked_histogram_equalizer i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_pixel, .req_last,
      .rsp_valid, .rsp_ready, .rsp_level, .rsp_last_out,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   mhe_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_pixel, .req_last,
      .rsp_valid, .rsp_ready, .rsp_level, .rsp_last_out,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .outstanding
   );

   // Watchdog.
   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off when requested.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            n = quiet ? 0 : $urandom_range(0, 4);
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // One input transaction, followed by a random gap.
   task automatic send(logic op, logic [7:0] pix, logic last);
      int gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel <= pix;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      sent++;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Setup and access cycle of a register write.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] pick_pixel(int style, int idx);
      case (style)
         0: return 8'($urandom);
         1: return 8'($urandom_range(0, 3) * 60 + 7);
         2: return 8'd93;
         default: return 8'(idx * 37);
      endcase
   endfunction

   // Full volume: configure, counting pass, mapping pass, wait until all levels are back.
   task automatic run_volume(int fd, int md, int sc, int mg, int ml, int gn,
                             int len0, int len1, int style);
      write_reg(mhe_pkg::REG_FAST_DIM, fd);
      write_reg(mhe_pkg::REG_MID_DIM, md);
      write_reg(mhe_pkg::REG_SLICE_COUNT, sc);
      write_reg(mhe_pkg::REG_MARGIN, mg);
      write_reg(mhe_pkg::REG_MAX_LEVEL, ml);
      write_reg(mhe_pkg::REG_GAIN, gn);
      for (int p = 0; p < len0; p++) send(1'b0, pick_pixel(style, p), p == len0 - 1);
      for (int p = 0; p < len1; p++) send(1'b1, 8'($urandom), p == len1 - 1);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      volumes++;
   endtask

   function automatic int pick_extent();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(1024, 2047);
      return $urandom_range(1, 6);
   endfunction

   initial begin
      int fd, md, sc, mg, ml, gn, len0, len1, cap;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: everything outside the window, a window of four pixels, extreme registers.
      run_volume(256, 256, 1, 64, 255, 16384, 6, 3, 2);
      run_volume(3, 3, 1, 0, 255, 16384, 9, 4, 3);
      run_volume(0, 2047, 0, 1023, 0, 65535, 3, 2, 0);
      run_volume(4, 4, 3, 0, 1, 32768, 16, 4, 0);
      run_volume(5, 5, 1, 1, 128, 0, 10, 3, 3);

      // Random volumes; mostly whole volumes of small extents, some cut short.
      while (sent < 1350) begin
         quiet = ($urandom_range(0, 3) == 0);
         fd = pick_extent();
         md = pick_extent();
         sc = $urandom_range(0, 6);
         mg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 2);
         case ($urandom_range(0, 5))
            0: ml = 255;
            1: ml = 0;
            default: ml = $urandom_range(1, 255);
         endcase
         case ($urandom_range(0, 3))
            0: gn = 16384;
            1: gn = 32768;
            default: gn = $urandom_range(0, 65535);
         endcase
         cap = (fd == 0 ? 1 : fd > 1024 ? 1024 : fd) * (md == 0 ? 1 : md > 1024 ? 1024 : md) *
               (sc == 0 ? 1 : sc);
         if ($urandom_range(0, 4) == 0 || cap > 150) len0 = $urandom_range(1, 80);
         else len0 = cap;
         len1 = $urandom_range(1, 40);
         // Once, fill the mapping pipeline against a long receiver stall.
         if (volumes == 8) begin
            quiet = 1'b1;
            long_hold = 1'b1;
            len1 = 40;
         end
         run_volume(fd, md, sc, mg, ml, gn, len0, len1, $urandom_range(0, 3));
      end

      quiet = 1'b0;
      for (int c = 0; c < 5000 && outstanding != 0; c++) @(posedge clock);
      leftover = outstanding;
      repeat (20) @(posedge clock);
      $display("Sent %0d pixels in %0d volumes with varied extents, margins, levels and gains.",
               sent, volumes);
      $display("Levels still awaited at the end: %0d.", leftover);
      if (fail_count == 0 && leftover == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/mhe_pkg.sv
sv/masked_histogram_equalizer.sv
bench/mhe_checker.sv
bench/masked_histogram_equalizer_tb.sv
